// ----- hdl/rie_pkg.sv -----
// ============================================================================
// rie_pkg
// types, opcodes and constants shared by the instruction execute block
// ============================================================================
package rie_pkg;

    localparam int MEMORY_WORDS_DEFAULT  = 1024;
    // program line count, fixed to match the 10-bit pc, target and start fields
    localparam int PROGRAM_LINES         = 1024;
    localparam int NUM_REGS              = 16;
    localparam logic [31:0] STACK_RESET  = 32'd4092;
    localparam logic [3:0]  LINK_REG     = 4'd15;
    localparam logic [3:0]  STACK_REG    = 4'd14;

    typedef enum logic [4:0] {
        OP_ADD   = 5'd0,
        OP_SUB   = 5'd1,
        OP_MUL   = 5'd2,
        OP_DIV   = 5'd3,
        OP_MOD   = 5'd4,
        OP_CMP   = 5'd5,
        OP_AND   = 5'd6,
        OP_OR    = 5'd7,
        OP_NOT   = 5'd8,
        OP_MOV   = 5'd9,
        OP_LSL   = 5'd10,
        OP_LSR   = 5'd11,
        OP_ASR   = 5'd12,
        OP_NOP   = 5'd13,
        OP_LD    = 5'd14,
        OP_ST    = 5'd15,
        OP_BEQ   = 5'd16,
        OP_BGT   = 5'd17,
        OP_B     = 5'd18,
        OP_CALL  = 5'd19,
        OP_RET   = 5'd20,
        OP_PRINT = 5'd21
    } op_t;

    localparam logic [1:0] MOD_ABS  = 2'd1;
    localparam logic [1:0] MOD_HIGH = 2'd2;

    typedef struct packed {
        logic [4:0]         func;
        logic [1:0]         modifier;
        logic [3:0]         dest_reg;
        logic [3:0]         src_reg;
        logic               operand_is_register;
        logic [3:0]         operand_reg;
        logic signed [31:0] immediate;
        logic [9:0]         branch_target;
    } in_beat_t;

    typedef struct packed {
        logic [9:0]         next_pc;
        logic               print_valid;
        logic signed [31:0] print_value;
        logic               eq_flag;
        logic               gt_flag;
    } out_beat_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_MEM,
        ST_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic clear_step;
        logic capture;
        logic exec;
        logic div_start;
        logic div_step;
        logic mem_finish;
        logic out_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_done;
        logic is_div;
        logic is_mem;
        logic div_done;
    } status_t;

endpackage

// ----- hdl/rie_ram.sv -----
// ============================================================================
// rie_ram
// generic single port ram with registered read
// ============================================================================
module rie_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ----- hdl/rie_ctrl.sv -----
// ============================================================================
// rie_ctrl
// sequencer: memory clear, operand read, divide iterations, memory access
// ============================================================================
module rie_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              out_full,
    input  rie_pkg::status_t  status,
    output rie_pkg::cmd_t     cmd
);

    rie_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rie_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            rie_pkg::ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_done)
                begin
                    state_next = rie_pkg::ST_IDLE;
                end
            end
            rie_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = rie_pkg::ST_READ;
                end
            end
            rie_pkg::ST_READ:
            begin
                if (status.is_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = rie_pkg::ST_DIV;
                end
                else if (status.is_mem)
                begin
                    state_next = rie_pkg::ST_MEM;
                end
                else
                begin
                    cmd.exec   = 1'b1;
                    state_next = rie_pkg::ST_DONE;
                end
            end
            rie_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                begin
                    cmd.div_step = 1'b0;
                    cmd.exec     = 1'b1;
                    state_next   = rie_pkg::ST_DONE;
                end
            end
            rie_pkg::ST_MEM:
            begin
                cmd.mem_finish = 1'b1;
                state_next     = rie_pkg::ST_DONE;
            end
            rie_pkg::ST_DONE:
            begin
                if (!out_full)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = rie_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rie_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/rie_datapath.sv -----
// ============================================================================
// rie_datapath
// register file, flags, pc, operand shaping, alu, serial divider, data memory
// ============================================================================
module rie_datapath #(
    parameter int MEMORY_WORDS  = rie_pkg::MEMORY_WORDS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [9:0]         cfg_data,
    input  rie_pkg::in_beat_t  in_data,
    input  rie_pkg::cmd_t      cmd,
    output rie_pkg::status_t   status,
    output rie_pkg::out_beat_t result
);

    localparam int AW = $clog2(MEMORY_WORDS);
    localparam int PW = $clog2(rie_pkg::PROGRAM_LINES);

    rie_pkg::in_beat_t ins_reg;
    logic [31:0] regs_reg [rie_pkg::NUM_REGS];
    logic [31:0] a_reg, b_reg, d_reg;
    logic [PW-1:0] pc_reg;
    logic eq_reg, gt_reg;
    logic [AW-1:0] clr_reg;
    logic clr_done_reg;

    // -------- operand read (registered at capture) --------
    logic [31:0] imm_u, imm_in, imm_shaped;
    assign imm_u  = ins_reg.immediate;
    assign imm_in = in_data.immediate;
    always_comb
    begin
        priority if (in_data.modifier == rie_pkg::MOD_ABS)
        begin
            imm_shaped = imm_in[31] ? (32'd0 - imm_in) : imm_in;
        end
        else if (in_data.modifier == rie_pkg::MOD_HIGH)
        begin
            imm_shaped = {imm_in[15:0], 16'd0};
        end
        else
        begin
            imm_shaped = imm_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ins_reg <= in_data;
            a_reg   <= regs_reg[in_data.src_reg];
            b_reg   <= in_data.operand_is_register ? regs_reg[in_data.operand_reg]
                                                   : imm_shaped;
            d_reg   <= regs_reg[in_data.dest_reg];
        end
    end

    // -------- address --------
    logic [31:0] addr_sum, addr_adj;
    logic [29:0] word_idx;
    logic        idx_ok;
    assign addr_sum = a_reg + imm_u;
    // round toward zero for negative addresses
    assign addr_adj = addr_sum[31] ? addr_sum + 32'd3 : addr_sum;
    assign word_idx = addr_adj[31:2];
    assign idx_ok   = !addr_adj[31] && ({2'b00, word_idx} < 32'(MEMORY_WORDS));

    // -------- serial divider (restoring, one bit a cycle) --------
    logic [31:0] dvd_reg, dvs_reg, quo_reg, rem_reg;
    logic        qneg_reg, rneg_reg;
    logic [5:0]  cnt_reg;
    logic [32:0] trial;
    assign trial = {rem_reg, dvd_reg[31]} - {1'b0, dvs_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            dvd_reg  <= a_reg[31] ? 32'd0 - a_reg : a_reg;
            dvs_reg  <= b_reg[31] ? 32'd0 - b_reg : b_reg;
            rem_reg  <= '0;
            quo_reg  <= '0;
            qneg_reg <= a_reg[31] ^ b_reg[31];
            rneg_reg <= a_reg[31];
            cnt_reg  <= 6'd32;
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= {dvd_reg[30:0], 1'b0};
            if (!trial[32])
            begin
                rem_reg <= trial[31:0];
                quo_reg <= {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[30:0], dvd_reg[31]};
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
            cnt_reg <= cnt_reg - 6'd1;
        end
    end

    // -------- data memory --------
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [31:0]   ram_wdata, ram_rdata;
    logic          is_ld, is_st;
    assign is_ld = ins_reg.func == rie_pkg::OP_LD;
    assign is_st = ins_reg.func == rie_pkg::OP_ST;

    always_comb
    begin
        if (!clr_done_reg)
        begin
            ram_we    = 1'b1;
            ram_addr  = clr_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = cmd.mem_finish && is_st && idx_ok;
            ram_addr  = word_idx[AW-1:0];
            ram_wdata = d_reg;
        end
    end

    rie_ram #(.WIDTH(32), .DEPTH(MEMORY_WORDS)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg      <= '0;
            clr_done_reg <= 1'b0;
        end
        else if (cmd.clear_step && !clr_done_reg)
        begin
            clr_reg <= clr_reg + AW'(1);
            if (clr_reg == AW'(MEMORY_WORDS - 1))
            begin
                clr_done_reg <= 1'b1;
            end
        end
    end

    // -------- execute --------
    logic [PW-1:0] pc_inc, target;
    logic [4:0]    sh;
    logic          wr_en;
    logic [3:0]    wr_sel;
    logic [31:0]   wr_val;
    logic [PW-1:0] pc_new;
    logic          eq_new, gt_new;
    logic [31:0]   mul_full;

    assign pc_inc   = pc_reg + PW'(1);
    assign target   = PW'(ins_reg.branch_target);
    assign sh       = b_reg[4:0];
    assign mul_full = a_reg * b_reg;

    always_comb
    begin
        wr_en  = 1'b0;
        wr_sel = ins_reg.dest_reg;
        wr_val = '0;
        pc_new = pc_inc;
        eq_new = eq_reg;
        gt_new = gt_reg;
        case (ins_reg.func)
            rie_pkg::OP_ADD: begin wr_en = 1'b1; wr_val = a_reg + b_reg; end
            rie_pkg::OP_SUB: begin wr_en = 1'b1; wr_val = a_reg - b_reg; end
            rie_pkg::OP_MUL: begin wr_en = 1'b1; wr_val = mul_full; end
            rie_pkg::OP_DIV:
            begin
                wr_en  = b_reg != 32'd0;
                wr_val = qneg_reg ? 32'd0 - quo_reg : quo_reg;
            end
            rie_pkg::OP_MOD:
            begin
                wr_en  = b_reg != 32'd0;
                wr_val = rneg_reg ? 32'd0 - rem_reg : rem_reg;
            end
            rie_pkg::OP_CMP:
            begin
                eq_new = d_reg == b_reg;
                gt_new = $signed(d_reg) > $signed(b_reg);
            end
            rie_pkg::OP_AND: begin wr_en = 1'b1; wr_val = a_reg & b_reg; end
            rie_pkg::OP_OR:  begin wr_en = 1'b1; wr_val = a_reg | b_reg; end
            rie_pkg::OP_NOT: begin wr_en = 1'b1; wr_val = ~b_reg; end
            rie_pkg::OP_MOV: begin wr_en = 1'b1; wr_val = b_reg; end
            rie_pkg::OP_LSL: begin wr_en = 1'b1; wr_val = a_reg << sh; end
            rie_pkg::OP_LSR: begin wr_en = 1'b1; wr_val = a_reg >> sh; end
            rie_pkg::OP_ASR:
            begin
                wr_en  = 1'b1;
                wr_val = 32'($signed(a_reg) >>> sh);
            end
            rie_pkg::OP_BEQ: if (eq_reg) pc_new = target;
            rie_pkg::OP_BGT: if (gt_reg) pc_new = target;
            rie_pkg::OP_B:   pc_new = target;
            rie_pkg::OP_CALL:
            begin
                wr_en  = 1'b1;
                wr_sel = rie_pkg::LINK_REG;
                wr_val = 32'(pc_reg) + 32'd1;
                pc_new = target;
            end
            rie_pkg::OP_RET: pc_new = regs_reg[rie_pkg::LINK_REG][PW-1:0];
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < rie_pkg::NUM_REGS; i++)
            begin
                regs_reg[i] <= '0;
            end
            regs_reg[rie_pkg::STACK_REG] <= rie_pkg::STACK_RESET;
            pc_reg <= '0;
            eq_reg <= 1'b0;
            gt_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                pc_reg <= PW'(cfg_data);
            end
            if (cmd.exec)
            begin
                if (wr_en)
                begin
                    regs_reg[wr_sel] <= wr_val;
                end
                pc_reg <= pc_new;
                eq_reg <= eq_new;
                gt_reg <= gt_new;
            end
            if (cmd.mem_finish)
            begin
                if (is_ld && idx_ok)
                begin
                    regs_reg[ins_reg.dest_reg] <= ram_rdata;
                end
                pc_reg <= pc_inc;
            end
        end
    end

    assign status.clear_done = clr_done_reg;
    assign status.is_div     = ins_reg.func == rie_pkg::OP_DIV || ins_reg.func == rie_pkg::OP_MOD;
    assign status.is_mem     = is_ld || is_st;
    assign status.div_done   = cnt_reg == 6'd0;

    assign result.next_pc     = 10'(pc_reg);
    assign result.print_valid = ins_reg.func == rie_pkg::OP_PRINT;
    assign result.print_value = (ins_reg.func == rie_pkg::OP_PRINT) ? d_reg : 32'd0;
    assign result.eq_flag     = eq_reg;
    assign result.gt_flag     = gt_reg;

endmodule

// ----- hdl/risc_instruction_execute.sv -----
// ============================================================================
// risc_instruction_execute
// executes one decoded instruction of a small 32-bit risc per input beat
// ============================================================================
// After reset the block sweeps its data memory to zero, one word a cycle,
// and accepts no beat meanwhile; start_pc may be written at any idle time
// and loads pc at once. One instruction is in flight at a time: the accept
// edge also captures the operands, then most operations execute; ld/st pass
// instead through the memory state (registered memory read), and div/mod
// through the divide state, where the serial divider retires one quotient
// bit a cycle. The result register loads from the done state once the output
// is not full, and a new beat is taken the cycle after it loads. The output
// register lets the next beat be accepted while the previous result still
// waits downstream.
module risc_instruction_execute #(
    parameter int MEMORY_WORDS  = rie_pkg::MEMORY_WORDS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [9:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  rie_pkg::in_beat_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output rie_pkg::out_beat_t out_data
);

    rie_pkg::cmd_t      cmd;
    rie_pkg::status_t   status;
    rie_pkg::out_beat_t result;
    logic               out_valid_reg;
    rie_pkg::out_beat_t out_data_reg;

    rie_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .out_full (out_valid_reg && out_stall),
        .status   (status),
        .cmd      (cmd)
    );

    rie_datapath #(
        .MEMORY_WORDS  (MEMORY_WORDS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_data  (in_data),
        .cmd      (cmd),
        .status   (status),
        .result   (result)
    );

    // output beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // a result is never loaded over one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid_reg && out_stall))
        else $error("result overwritten");

    // input is only taken once memory clear is done
    a_clear_first: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> status.clear_done)
        else $error("accept before clear");

    // divider steps only while counting
    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> !status.div_done)
        else $error("divider overrun");

endmodule

// ----- verif/risc_instruction_execute_chk.sv -----
// ============================================================================
// risc_instruction_execute_chk
// watches both channels, predicts every result beat and compares it
// ============================================================================
`timescale 1ns / 1ps

module risc_instruction_execute_chk (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [9:0]         cfg_data,
    input  logic               in_valid,
    input  logic               in_stall,
    input  rie_pkg::in_beat_t  in_data,
    input  logic               out_valid,
    input  logic               out_stall,
    input  rie_pkg::out_beat_t out_data,
    output int                 fails,
    output int                 pending
);

    logic [31:0] regs [rie_pkg::NUM_REGS];
    logic [31:0] dmem [rie_pkg::MEMORY_WORDS_DEFAULT];
    logic [9:0]  pc;
    logic        eq_f;
    logic        gt_f;
    rie_pkg::out_beat_t results_due [$];

    function automatic logic [31:0] shaped_operand(rie_pkg::in_beat_t it);
        logic [31:0] imm;
        imm = it.immediate;
        if (it.operand_is_register)
            return regs[it.operand_reg];
        if (it.modifier == rie_pkg::MOD_ABS)
            return imm[31] ? -imm : imm;
        if (it.modifier == rie_pkg::MOD_HIGH)
            return imm << 16;
        return imm;
    endfunction

    // updates the architectural state and returns the beat the block owes
    function automatic rie_pkg::out_beat_t execute_instruction(rie_pkg::in_beat_t it);
        rie_pkg::out_beat_t r;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] addr;
        longint      x;
        longint      y;
        longint      widx;
        logic [9:0]  nxt;
        a   = regs[it.src_reg];
        b   = shaped_operand(it);
        nxt = pc + 10'd1;
        r   = '0;
        case (it.func)
            rie_pkg::OP_ADD: regs[it.dest_reg] = a + b;
            rie_pkg::OP_SUB: regs[it.dest_reg] = a - b;
            rie_pkg::OP_MUL: regs[it.dest_reg] = a * b;
            rie_pkg::OP_DIV, rie_pkg::OP_MOD:
            begin
                if (b != 0)
                begin
                    x = longint'($signed(a));
                    y = longint'($signed(b));
                    regs[it.dest_reg] = (it.func == rie_pkg::OP_DIV) ? 32'(x / y)
                                                                     : 32'(x % y);
                end
            end
            rie_pkg::OP_CMP:
            begin
                eq_f = ($signed(regs[it.dest_reg]) == $signed(b));
                gt_f = ($signed(regs[it.dest_reg]) > $signed(b));
            end
            rie_pkg::OP_AND: regs[it.dest_reg] = a & b;
            rie_pkg::OP_OR:  regs[it.dest_reg] = a | b;
            rie_pkg::OP_NOT: regs[it.dest_reg] = ~b;
            rie_pkg::OP_MOV: regs[it.dest_reg] = b;
            rie_pkg::OP_LSL: regs[it.dest_reg] = a << b[4:0];
            rie_pkg::OP_LSR: regs[it.dest_reg] = a >> b[4:0];
            rie_pkg::OP_ASR: regs[it.dest_reg] = $signed(a) >>> b[4:0];
            rie_pkg::OP_LD, rie_pkg::OP_ST:
            begin
                addr = a + it.immediate;
                widx = longint'($signed(addr)) / 4;
                if (widx >= 0 && widx < rie_pkg::MEMORY_WORDS_DEFAULT)
                begin
                    if (it.func == rie_pkg::OP_LD)
                        regs[it.dest_reg] = dmem[widx];
                    else
                        dmem[widx] = regs[it.dest_reg];
                end
            end
            rie_pkg::OP_BEQ:   if (eq_f) nxt = it.branch_target;
            rie_pkg::OP_BGT:   if (gt_f) nxt = it.branch_target;
            rie_pkg::OP_B:     nxt = it.branch_target;
            rie_pkg::OP_CALL:
            begin
                regs[rie_pkg::LINK_REG] = {22'd0, pc} + 32'd1;
                nxt = it.branch_target;
            end
            rie_pkg::OP_RET:   nxt = regs[rie_pkg::LINK_REG][9:0];
            rie_pkg::OP_PRINT:
            begin
                r.print_valid = 1'b1;
                r.print_value = regs[it.dest_reg];
            end
            default:  ;
        endcase
        pc = nxt;
        r.next_pc = pc;
        r.eq_flag = eq_f;
        r.gt_flag = gt_f;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rie_pkg::out_beat_t want;
        rie_pkg::out_beat_t due;
        if (!rst_n)
        begin
            foreach (regs[i]) regs[i] = '0;
            regs[rie_pkg::STACK_REG] = rie_pkg::STACK_RESET;
            foreach (dmem[i]) dmem[i] = '0;
            pc      = '0;
            eq_f    = 1'b0;
            gt_f    = 1'b0;
            fails   = 0;
            results_due.delete();
            pending = 0;
        end
        else
        begin
            // result side first, so a beat can never meet its own expectation
            if (out_valid && !out_stall)
            begin
                if (results_due.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected result beat %p", out_data);
                end
                else
                begin
                    want = results_due.pop_front();
                    if (out_data.next_pc !== want.next_pc
                        || out_data.print_valid !== want.print_valid
                        || out_data.print_value !== want.print_value
                        || out_data.eq_flag !== want.eq_flag
                        || out_data.gt_flag !== want.gt_flag)
                    begin
                        fails++;
                        if (fails <= 10)
                            $display("mismatch: expected %p, got %p", want, out_data);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                due = execute_instruction(in_data);
                results_due = {results_due, due};
            end
            if (cfg_we)
            begin
                pc = cfg_data;
            end
            pending = results_due.size();
        end
    end

endmodule

// ----- verif/risc_instruction_execute_tb.sv -----
// ============================================================================
// risc_instruction_execute_tb
// random and directed instruction streams with a predicting checker
// ============================================================================
// The top only makes stimulus: a directed run over every operation but b and
// nop, and corners, then phases of random instructions, with start_pc rewritten
// between phases once the block has drained. The checker beside the block
// predicts each result beat and counts mismatches for the verdict.
`timescale 1ns / 1ps

module risc_instruction_execute_tb;

    localparam int WATCHDOG_CYCLES = 5000;   // covers the memory clear pass
    localparam int DRAIN_CYCLES    = 40;     // longer than a div or mod
    localparam int LONG_HOLD       = 300;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [9:0]         cfg_data;
    logic               in_valid;
    logic               in_stall;
    rie_pkg::in_beat_t  in_data;
    logic               out_valid;
    logic               out_stall;
    rie_pkg::out_beat_t out_data;

    int fails;
    int pending;
    int idle_cycles;
    bit no_gaps;        // a stretch where neither side idles
    bit hold_request;   // asks the receiver for one long hold-off

    risc_instruction_execute dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    risc_instruction_execute_chk chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .fails     (fails),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // watchdog: cycles in which neither channel moves a beat
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_CYCLES)
            begin
                $display("risc_instruction_execute verification failed");
                $finish;
            end
        end
    end

    // receiver: random stall before every result beat, plus one long hold
    initial
    begin
        int n;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            n = no_gaps ? 0 : $urandom_range(0, 16);
            if (hold_request)
            begin
                n = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    // immediate values with the extremes well represented
    function automatic logic [31:0] pick_immediate();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 40);
            2: return 32'($urandom_range(0, 80)) - 32'd40;
            3: return 32'h8000_0000;
            4: return 32'h7fff_ffff;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    function automatic rie_pkg::in_beat_t make_instr(logic [4:0] f, logic [3:0] rd,
                                                     logic [3:0] rs, logic use_reg,
                                                     logic [3:0] ro, logic [31:0] imm,
                                                     logic [1:0] m);
        rie_pkg::in_beat_t it;
        it.func                = f;
        it.modifier            = m;
        it.dest_reg            = rd;
        it.src_reg             = rs;
        it.operand_is_register = use_reg;
        it.operand_reg         = ro;
        it.immediate           = imm;
        it.branch_target       = 10'($urandom_range(0, 1023));
        return it;
    endfunction

    // random instruction; ld/st mostly go through the stack pointer or r0, with
    // offsets that land both inside and outside the data memory
    function automatic rie_pkg::in_beat_t random_instr();
        rie_pkg::in_beat_t it;
        logic [63:0]       raw;
        raw = {$urandom, $urandom};
        it = raw[$bits(rie_pkg::in_beat_t)-1:0];
        it.immediate = pick_immediate();
        it.modifier  = 2'($urandom_range(0, 3));
        case ($urandom_range(0, 9))
            0, 1:
            begin
                it.func      = $urandom_range(0, 1) ? rie_pkg::OP_LD : rie_pkg::OP_ST;
                it.src_reg   = $urandom_range(0, 1) ? rie_pkg::STACK_REG : 4'd0;
                it.immediate = 32'($urandom_range(0, 8400)) - 32'd4200;
            end
            2: it.func = 5'($urandom_range(0, 31));
            3: it.func = $urandom_range(0, 1) ? rie_pkg::OP_DIV : rie_pkg::OP_MOD;
            4: it.func = 5'($urandom_range(rie_pkg::OP_BEQ, rie_pkg::OP_PRINT));
            default: it.func = 5'($urandom_range(rie_pkg::OP_ADD, rie_pkg::OP_ASR));
        endcase
        // keep the stack pointer alive most of the time
        if (it.dest_reg == rie_pkg::STACK_REG && it.func != rie_pkg::OP_ST
            && it.func != rie_pkg::OP_PRINT && $urandom_range(0, 9) != 0)
            it.dest_reg = 4'd1;
        return it;
    endfunction

    task automatic send_beat(rie_pkg::in_beat_t it);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (in_stall);
    endtask

    // the sender pauses until every result is back, then start_pc is rewritten
    task automatic drain_and_set_start(logic [9:0] v);
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    initial
    begin
        logic [9:0] start_values [6];
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        in_data      = '0;
        no_gaps      = 1'b0;
        hold_request = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        start_values = '{10'd1023, 10'd0, 10'd512, 10'd1, 10'd777, 10'd1022};
        drain_and_set_start(10'd1023);

        // directed corners
        send_beat(make_instr(rie_pkg::OP_MOV, 4'd1, 4'd0, 1'b0, 4'd0, 32'h8000_0000, 2'd0));
        send_beat(make_instr(rie_pkg::OP_MOV, 4'd2, 4'd0, 1'b0, 4'd0, 32'hffff_ffff, 2'd0));
        send_beat(make_instr(rie_pkg::OP_DIV, 4'd3, 4'd1, 1'b1, 4'd2, 32'd0, 2'd0));
        send_beat(make_instr(rie_pkg::OP_MOD, 4'd4, 4'd1, 1'b1, 4'd2, 32'd0, 2'd0));
        // by zero
        send_beat(make_instr(rie_pkg::OP_DIV, 4'd3, 4'd2, 1'b0, 4'd0, 32'd0, 2'd0));
        send_beat(make_instr(rie_pkg::OP_MOD, 4'd4, 4'd1, 1'b0, 4'd0, 32'd7, 2'd0));
        send_beat(make_instr(rie_pkg::OP_MOV, 4'd5, 4'd0, 1'b0, 4'd0, 32'h8000_0000,
                             rie_pkg::MOD_ABS));
        send_beat(make_instr(rie_pkg::OP_ADD, 4'd6, 4'd2, 1'b0, 4'd0, 32'hffff_fff9,
                             rie_pkg::MOD_ABS));
        send_beat(make_instr(rie_pkg::OP_SUB, 4'd7, 4'd1, 1'b0, 4'd0, 32'h0001_ffff,
                             rie_pkg::MOD_HIGH));
        send_beat(make_instr(rie_pkg::OP_MUL, 4'd8, 4'd2, 1'b0, 4'd0, 32'h7fff_ffff, 2'd3));
        send_beat(make_instr(rie_pkg::OP_LSL, 4'd9, 4'd2, 1'b0, 4'd0, 32'd37, 2'd0));
        send_beat(make_instr(rie_pkg::OP_LSR, 4'd10, 4'd1, 1'b0, 4'd0, 32'd31, 2'd0));
        send_beat(make_instr(rie_pkg::OP_ASR, 4'd11, 4'd1, 1'b1, 4'd2, 32'd0, 2'd0));
        send_beat(make_instr(rie_pkg::OP_AND, 4'd12, 4'd2, 1'b0, 4'd0, 32'h5a5a_a5a5, 2'd0));
        send_beat(make_instr(rie_pkg::OP_OR, 4'd13, 4'd1, 1'b1, 4'd12, 32'd0, 2'd0));
        send_beat(make_instr(rie_pkg::OP_NOT, 4'd0, 4'd0, 1'b1, 4'd13, 32'd0, 2'd0));
        send_beat(make_instr(rie_pkg::OP_ST, 4'd2, rie_pkg::STACK_REG, 1'b1, 4'd3, 32'd0,
                             rie_pkg::MOD_HIGH));
        send_beat(make_instr(rie_pkg::OP_LD, 4'd3, rie_pkg::STACK_REG, 1'b0, 4'd0, 32'd0,
                             2'd0));
        // past end
        send_beat(make_instr(rie_pkg::OP_LD, 4'd3, rie_pkg::STACK_REG, 1'b0, 4'd0, 32'd4,
                             2'd0));
        // negative
        send_beat(make_instr(rie_pkg::OP_ST, 4'd1, 4'd5, 1'b0, 4'd0, 32'd0, 2'd0));
        send_beat(make_instr(rie_pkg::OP_CMP, 4'd1, 4'd0, 1'b1, 4'd1, 32'd0, 2'd0));
        send_beat(make_instr(rie_pkg::OP_BEQ, 4'd0, 4'd0, 1'b0, 4'd0, 32'd0, 2'd0));
        send_beat(make_instr(rie_pkg::OP_CMP, 4'd2, 4'd0, 1'b1, 4'd1, 32'd0, 2'd0));
        send_beat(make_instr(rie_pkg::OP_BGT, 4'd0, 4'd0, 1'b0, 4'd0, 32'd0, 2'd0));
        send_beat(make_instr(rie_pkg::OP_CALL, 4'd0, 4'd0, 1'b0, 4'd0, 32'd0, 2'd0));
        send_beat(make_instr(rie_pkg::OP_RET, 4'd0, 4'd0, 1'b0, 4'd0, 32'd0, 2'd0));
        send_beat(make_instr(rie_pkg::OP_PRINT, 4'd2, 4'd0, 1'b0, 4'd0, 32'd0, 2'd0));
        send_beat(make_instr(5'd31, 4'd0, 4'd0, 1'b0, 4'd0, 32'd0, 2'd0));

        // random phases; one gapless phase and one long receiver hold-off
        for (int ph = 0; ph < 6; ph++)
        begin
            drain_and_set_start(start_values[ph]);
            no_gaps      = (ph == 2);
            hold_request = (ph == 4);
            for (int k = 0; k < 335; k++)
                send_beat(random_instr());
        end
        no_gaps  = 1'b0;
        in_valid <= 1'b0;

        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fails == 0)
            $display("risc_instruction_execute verification clean");
        else
            $display("risc_instruction_execute verification failed");
        $finish;
    end

endmodule
